/* design/ready_to_drive_status_fsm_macros.svh */
// assertion macros for the ready-to-drive status supervisor
// used by ready_to_drive_status_fsm; no other dependencies
`ifndef READY_TO_DRIVE_STATUS_FSM_MACROS_SVH
`define READY_TO_DRIVE_STATUS_FSM_MACROS_SVH
`ifndef SYNTHESIS
`define RTDS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtds assertion failed");
`define RTDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtds assertion failed");
`else
`define RTDS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RTDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/rtds_pkg.sv */
// types and codes for the ready-to-drive status supervisor
// no dependencies; used by the interfaces, rtds_step and the top level
package rtds_pkg;

  localparam int PEDAL_W = 10;
  localparam int VOLT_W  = 14;
  localparam int COND_W  = 7;
  localparam int STAT_W  = 3;
  localparam int LIGHT_W = 2;
  localparam int CMD_W   = 2;
  localparam int ERR_W   = 4;
  localparam int EVT_W   = 2;
  localparam int REG_W   = 2;
  localparam int DATA_W  = 14;

  localparam logic [STAT_W-1:0] ST_INIT  = 3'd0;
  localparam logic [STAT_W-1:0] ST_READY = 3'd1;
  localparam logic [STAT_W-1:0] ST_RTD   = 3'd2;
  localparam logic [STAT_W-1:0] ST_RUN   = 3'd3;
  localparam logic [STAT_W-1:0] ST_ERR   = 3'd4;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERROR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [LIGHT_W-1:0] LIGHT_OFF   = 2'd0;
  localparam logic [LIGHT_W-1:0] LIGHT_ON    = 2'd1;
  localparam logic [LIGHT_W-1:0] LIGHT_BLINK = 2'd2;

  localparam logic [EVT_W-1:0] EVT_NONE    = 2'd0;
  localparam logic [EVT_W-1:0] EVT_RAISED  = 2'd1;
  localparam logic [EVT_W-1:0] EVT_CLEARED = 2'd2;

  localparam logic [REG_W-1:0] REG_IMPL_APPS  = 2'd0;
  localparam logic [REG_W-1:0] REG_PLAUS_RST  = 2'd1;
  localparam logic [REG_W-1:0] REG_MIN_VOLT   = 2'd2;

  localparam int CB_PEDAL = 4;
  localparam int CB_NODES = 5;
  localparam int CB_VOLT  = 6;

  localparam logic [COND_W-1:0]  COND_RESET      = 7'h0F;
  localparam logic [PEDAL_W-1:0] IMPL_APPS_RESET = 10'd250;
  localparam logic [PEDAL_W-1:0] PLAUS_RST_RESET = 10'd50;
  localparam logic [VOLT_W-1:0]  MIN_VOLT_RESET  = 14'd3000;

  typedef struct packed {
    logic [PEDAL_W-1:0] implausible_apps_threshold;
    logic [PEDAL_W-1:0] plausible_reset_threshold;
    logic [VOLT_W-1:0]  minimum_bus_voltage;
  } cfg_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COND_W-1:0]  conditions;
    logic               vcu_led;
    logic [LIGHT_W-1:0] rtd_light;
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [PEDAL_W-1:0] accel_sensor_a;
    logic [PEDAL_W-1:0] accel_sensor_b;
    logic               brake_pressed;
    logic               rtd_button;
    logic               rear_node_running;
    logic               inverter_fault;
    logic [VOLT_W-1:0]  bus_voltage;
    logic               siren_done;
    logic [ERR_W-1:0]   error_sources;
    logic               error_asserted;
  } item_t;

  typedef struct packed {
    logic               siren_start;
    logic               siren_stop;
    logic [EVT_W-1:0]   impl_event;
  } pulses_t;

  typedef struct packed {
    state_t  st;
    pulses_t pulses;
  } result_t;

endpackage

/* design/rtds_in_if.sv */
// input item channel of the ready-to-drive status supervisor
// depends on rtds_pkg
interface rtds_in_if;
  logic                        valid;
  logic                        ready;
  logic [rtds_pkg::CMD_W-1:0]   command;
  logic [rtds_pkg::PEDAL_W-1:0] accel_sensor_a;
  logic [rtds_pkg::PEDAL_W-1:0] accel_sensor_b;
  logic                        brake_pressed;
  logic                        rtd_button;
  logic                        rear_node_running;
  logic                        inverter_fault;
  logic [rtds_pkg::VOLT_W-1:0]  bus_voltage;
  logic                        siren_done;
  logic [rtds_pkg::ERR_W-1:0]   error_sources;
  logic                        error_asserted;

  modport source (
    output valid, command, accel_sensor_a, accel_sensor_b, brake_pressed, rtd_button,
           rear_node_running, inverter_fault, bus_voltage, siren_done, error_sources,
           error_asserted,
    input  ready
  );
  modport sink (
    input  valid, command, accel_sensor_a, accel_sensor_b, brake_pressed, rtd_button,
           rear_node_running, inverter_fault, bus_voltage, siren_done, error_sources,
           error_asserted,
    output ready
  );
endinterface

/* design/rtds_out_if.sv */
// result channel of the ready-to-drive status supervisor
// depends on rtds_pkg
interface rtds_out_if;
  logic                        valid;
  logic                        ready;
  logic [rtds_pkg::STAT_W-1:0]  status;
  logic [rtds_pkg::COND_W-1:0]  conditions;
  logic                        vcu_led;
  logic [rtds_pkg::LIGHT_W-1:0] rtd_light;
  logic                        siren_start;
  logic                        siren_stop;
  logic [rtds_pkg::EVT_W-1:0]   implausibility_event;

  modport source (
    output valid, status, conditions, vcu_led, rtd_light, siren_start, siren_stop,
           implausibility_event,
    input  ready
  );
  modport sink (
    input  valid, status, conditions, vcu_led, rtd_light, siren_start, siren_stop,
           implausibility_event,
    output ready
  );
endinterface

/* design/rtds_cfg_if.sv */
// register write channel of the ready-to-drive status supervisor
// depends on rtds_pkg
interface rtds_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rtds_pkg::REG_W-1:0]  index;
  logic [rtds_pkg::DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/rtds_step.sv */
// one step of the supervisor: next state and pulses from the current state and one item
// depends on rtds_pkg
module rtds_step (
  input  rtds_pkg::state_t  cur,
  input  rtds_pkg::item_t   item,
  input  rtds_pkg::cfg_t    cfg,
  output rtds_pkg::state_t  nxt,
  output rtds_pkg::pulses_t pulses
);
  import rtds_pkg::*;

  logic [PEDAL_W-1:0] apps;
  logic [COND_W-1:0]  tick_cond;
  logic [EVT_W-1:0]   tick_event;
  logic               all_ok;

  assign apps = (item.accel_sensor_a > item.accel_sensor_b) ? item.accel_sensor_a
                                                            : item.accel_sensor_b;

  // pedal plausibility with hysteresis, node health, bus voltage
  always_comb begin
    tick_cond  = cur.conditions;
    tick_event = EVT_NONE;
    if (cur.conditions[CB_PEDAL]) begin
      if (item.brake_pressed && (apps > cfg.implausible_apps_threshold)) begin
        tick_cond[CB_PEDAL] = 1'b0;
        tick_event          = EVT_RAISED;
      end
    end else if (apps < cfg.plausible_reset_threshold) begin
      tick_cond[CB_PEDAL] = 1'b1;
      tick_event          = EVT_CLEARED;
    end
    tick_cond[CB_NODES] = item.rear_node_running && !item.inverter_fault;
    tick_cond[CB_VOLT]  = item.bus_voltage >= cfg.minimum_bus_voltage;
  end

  assign all_ok = &tick_cond;

  always_comb begin
    nxt    = cur;
    pulses = '0;
    unique case (item.command)
      CMD_TICK: begin
        nxt.conditions    = tick_cond;
        pulses.impl_event = tick_event;
        unique case (cur.status)
          ST_INIT: begin
            if (all_ok) begin
              nxt.vcu_led = 1'b0;
              nxt.status  = ST_READY;
            end
          end
          ST_READY: begin
            if (all_ok) begin
              if (item.brake_pressed) begin
                if (item.rtd_button) begin
                  pulses.siren_start = 1'b1;
                  nxt.status         = ST_RTD;
                end else begin
                  nxt.rtd_light = LIGHT_ON;
                end
              end else begin
                nxt.rtd_light = LIGHT_BLINK;
              end
            end else begin
              nxt.status    = ST_ERR;
              nxt.rtd_light = LIGHT_OFF;
              nxt.vcu_led   = 1'b1;
            end
          end
          ST_RTD: begin
            if (item.siren_done) begin
              if (cur.rtd_light != LIGHT_BLINK) begin
                nxt.rtd_light = LIGHT_OFF;
              end
              nxt.status = ST_RUN;
            end
          end
          ST_RUN: begin
            if (!all_ok) begin
              nxt.vcu_led = 1'b1;
              nxt.status  = ST_ERR;
            end
          end
          default: begin
            if (all_ok) begin
              nxt.vcu_led = 1'b0;
              nxt.status  = ST_READY;
            end
          end
        endcase
      end
      CMD_ERROR: begin
        if (item.error_asserted) begin
          nxt.conditions[ERR_W-1:0] = cur.conditions[ERR_W-1:0] & ~item.error_sources;
        end else begin
          nxt.conditions[ERR_W-1:0] = cur.conditions[ERR_W-1:0] | item.error_sources;
        end
      end
      CMD_RESET: begin
        if (cur.status == ST_RTD) begin
          pulses.siren_stop = 1'b1;
          nxt.status        = ST_READY;
        end else if (cur.status == ST_RUN) begin
          nxt.status = ST_READY;
        end
      end
      CMD_NONE: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

/* design/ready_to_drive_status_fsm.sv */
// ready-to-drive status supervisor, top level
// depends on rtds_pkg, rtds_in_if, rtds_out_if, rtds_cfg_if, rtds_step and the macro header
//
// channels: item (sink) takes ticks, error events and reset requests; result (source)
// returns one result per item, in order; cfg (sink) writes the three threshold
// registers, index 0 apps implausibility level, 1 plausibility reset level, 2 minimum
// bus voltage. cfg is always ready; the user must write it only while idle, which the
// block does not enforce. a transferred item is held in the input register, passes
// through rtds_step into the result register and stays there until taken.
// throughput: one item per cycle while results are taken; the step is one pass through
// rtds_step between input and result register, and the state updates in that pass.
// stall: when the result is not taken, the result register holds and the input
// register fills; item.ready drops only when both are full.
// reset (rst, synchronous): status init, conditions 0x0f, fault led on, light off,
// thresholds back to 250, 50 and 3000, both registers empty.
`include "ready_to_drive_status_fsm_macros.svh"
module ready_to_drive_status_fsm (
  input  logic       clk,
  input  logic       rst,
  rtds_in_if.sink    item,
  rtds_out_if.source result,
  rtds_cfg_if.sink   cfg
);
  import rtds_pkg::*;

  cfg_t    cfg_regs;
  state_t  state;
  state_t  state_next;
  pulses_t pulses_next;
  item_t   s1_item;
  logic    s1_valid;
  result_t res;
  logic    res_valid;
  logic    out_free;
  logic    s1_fire;
  logic    in_fire;

  assign out_free = !res_valid || result.ready;
  assign s1_fire  = s1_valid && out_free;
  assign item.ready = !s1_valid || out_free;
  assign in_fire  = item.valid && item.ready;
  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.implausible_apps_threshold <= IMPL_APPS_RESET;
      cfg_regs.plausible_reset_threshold  <= PLAUS_RST_RESET;
      cfg_regs.minimum_bus_voltage        <= MIN_VOLT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMPL_APPS: cfg_regs.implausible_apps_threshold <= cfg.data[PEDAL_W-1:0];
        REG_PLAUS_RST: cfg_regs.plausible_reset_threshold  <= cfg.data[PEDAL_W-1:0];
        REG_MIN_VOLT:  cfg_regs.minimum_bus_voltage        <= cfg.data[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.command           <= item.command;
      s1_item.accel_sensor_a    <= item.accel_sensor_a;
      s1_item.accel_sensor_b    <= item.accel_sensor_b;
      s1_item.brake_pressed     <= item.brake_pressed;
      s1_item.rtd_button        <= item.rtd_button;
      s1_item.rear_node_running <= item.rear_node_running;
      s1_item.inverter_fault    <= item.inverter_fault;
      s1_item.bus_voltage       <= item.bus_voltage;
      s1_item.siren_done        <= item.siren_done;
      s1_item.error_sources     <= item.error_sources;
      s1_item.error_asserted    <= item.error_asserted;
    end
  end

  rtds_step u_step (
    .cur    (state),
    .item   (s1_item),
    .cfg    (cfg_regs),
    .nxt    (state_next),
    .pulses (pulses_next)
  );

  // supervisor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.status     <= ST_INIT;
      state.conditions <= COND_RESET;
      state.vcu_led    <= 1'b1;
      state.rtd_light  <= LIGHT_OFF;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res.st     <= state_next;
      res.pulses <= pulses_next;
    end
  end

  assign result.valid                = res_valid;
  assign result.status               = res.st.status;
  assign result.conditions           = res.st.conditions;
  assign result.vcu_led              = res.st.vcu_led;
  assign result.rtd_light            = res.st.rtd_light;
  assign result.siren_start          = res.pulses.siren_start;
  assign result.siren_stop           = res.pulses.siren_stop;
  assign result.implausibility_event = res.pulses.impl_event;

  // fault led is off exactly in the driving-side states
  `RTDS_ASSERT_IMPLY(a_led_state, clk, rst, !state.vcu_led,
    (state.status == ST_READY) || (state.status == ST_RTD) || (state.status == ST_RUN))
  // siren start only goes out with the rtd sound status
  `RTDS_ASSERT_IMPLY(a_start_rtd, clk, rst, res_valid && res.pulses.siren_start,
    res.st.status == ST_RTD)
  // siren stop only goes out with the ready status
  `RTDS_ASSERT_IMPLY(a_stop_ready, clk, rst, res_valid && res.pulses.siren_stop,
    res.st.status == ST_READY)
  // a transferred item is held in the input register
  `RTDS_ASSERT_NEXT(a_in_held, clk, rst, in_fire, s1_valid)

endmodule

/* verif/tb_ready_to_drive_status_fsm.sv */
`timescale 1ns / 1ps
// self-checking testbench for ready_to_drive_status_fsm: directed and random ticks, error
// events and reset requests under random handshake gaps, checked against an in-bench predictor
// depends on rtds_pkg, rtds_in_if, rtds_out_if, rtds_cfg_if and the design under test
module tb_ready_to_drive_status_fsm;
  import rtds_pkg::*;

  localparam int LONG_HOLD = 60;
  localparam int MAX_PRINT = 40;

  logic clk = 1'b0;
  logic rst;

  rtds_in_if  item_ch ();
  rtds_out_if result_ch ();
  rtds_cfg_if cfg_ch ();

  ready_to_drive_status_fsm i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // predicted supervisor state and thresholds
  logic [STAT_W-1:0]  pred_status;
  logic [COND_W-1:0]  pred_cond;
  logic               pred_led;
  logic [LIGHT_W-1:0] pred_light;
  logic [PEDAL_W-1:0] pred_apps_lim;
  logic [PEDAL_W-1:0] pred_plaus_lim;
  logic [VOLT_W-1:0]  pred_min_volt;

  result_t expected_results[$];

  int   n_sent = 0;
  int   n_checked = 0;
  int   err_count = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  bit   src_idle = 1'b1;
  logic snk_idle;

  task automatic report(input string msg);
    err_count++;
    if (err_count <= MAX_PRINT) $display("%0t ERROR %s", $time, msg);
  endtask

  function automatic logic coin();
    return 1'($urandom_range(1, 0));
  endfunction

  task automatic predict_status_step(input item_t it);
    result_t r;
    logic [PEDAL_W-1:0] apps;
    logic all_ok;
    r = '0;
    if (it.command == CMD_TICK) begin
      apps = (it.accel_sensor_a > it.accel_sensor_b) ? it.accel_sensor_a : it.accel_sensor_b;
      // latched plausibility with hysteresis
      if (pred_cond[CB_PEDAL]) begin
        if (it.brake_pressed && apps > pred_apps_lim) begin
          pred_cond[CB_PEDAL] = 1'b0;
          r.pulses.impl_event = EVT_RAISED;
        end
      end else if (apps < pred_plaus_lim) begin
        pred_cond[CB_PEDAL] = 1'b1;
        r.pulses.impl_event = EVT_CLEARED;
      end
      pred_cond[CB_NODES] = it.rear_node_running && !it.inverter_fault;
      pred_cond[CB_VOLT] = it.bus_voltage >= pred_min_volt;
      all_ok = &pred_cond;
      case (pred_status)
        ST_INIT: begin
          if (all_ok) begin
            pred_led = 1'b0;
            pred_status = ST_READY;
          end
        end
        ST_READY: begin
          if (!all_ok) begin
            pred_status = ST_ERR;
            pred_light = LIGHT_OFF;
            pred_led = 1'b1;
          end else if (!it.brake_pressed) begin
            pred_light = LIGHT_BLINK;
          end else if (!it.rtd_button) begin
            pred_light = LIGHT_ON;
          end else begin
            r.pulses.siren_start = 1'b1;
            pred_status = ST_RTD;
          end
        end
        ST_RTD: begin
          if (it.siren_done) begin
            if (pred_light != LIGHT_BLINK) pred_light = LIGHT_OFF;
            pred_status = ST_RUN;
          end
        end
        ST_RUN: begin
          if (!all_ok) begin
            pred_led = 1'b1;
            pred_status = ST_ERR;
          end
        end
        default: begin
          if (all_ok) begin
            pred_led = 1'b0;
            pred_status = ST_READY;
          end
        end
      endcase
    end else if (it.command == CMD_ERROR) begin
      if (it.error_asserted) pred_cond[ERR_W-1:0] = pred_cond[ERR_W-1:0] & ~it.error_sources;
      else pred_cond[ERR_W-1:0] = pred_cond[ERR_W-1:0] | it.error_sources;
    end else if (it.command == CMD_RESET) begin
      if (pred_status == ST_RTD) begin
        r.pulses.siren_stop = 1'b1;
        pred_status = ST_READY;
      end else if (pred_status == ST_RUN) begin
        pred_status = ST_READY;
      end
    end
    r.st.status = pred_status;
    r.st.conditions = pred_cond;
    r.st.vcu_led = pred_led;
    r.st.rtd_light = pred_light;
    expected_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report($sformatf("result %0d: %s got %0d expected %0d", n_checked, name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("result with status %0d and no item pending", result_ch.status));
      return;
    end
    want = expected_results.pop_front();
    n_checked++;
    compare_field("status", 16'(result_ch.status), 16'(want.st.status));
    compare_field("conditions", 16'(result_ch.conditions), 16'(want.st.conditions));
    compare_field("vcu_led", 16'(result_ch.vcu_led), 16'(want.st.vcu_led));
    compare_field("rtd_light", 16'(result_ch.rtd_light), 16'(want.st.rtd_light));
    compare_field("siren_start", 16'(result_ch.siren_start), 16'(want.pulses.siren_start));
    compare_field("siren_stop", 16'(result_ch.siren_stop), 16'(want.pulses.siren_stop));
    compare_field("implausibility_event", 16'(result_ch.implausibility_event),
                  16'(want.pulses.impl_event));
  endtask

  // result side: checks every transfer, draws a stall per result while sink idling is on, long hold on request
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        check_result();
        stall_left = snk_idle ? $urandom_range(5, 0) : 0;
      end
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input item_t it);
    int gap;
    gap = src_idle ? $urandom_range(5, 0) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.command <= it.command;
    item_ch.accel_sensor_a <= it.accel_sensor_a;
    item_ch.accel_sensor_b <= it.accel_sensor_b;
    item_ch.brake_pressed <= it.brake_pressed;
    item_ch.rtd_button <= it.rtd_button;
    item_ch.rear_node_running <= it.rear_node_running;
    item_ch.inverter_fault <= it.inverter_fault;
    item_ch.bus_voltage <= it.bus_voltage;
    item_ch.siren_done <= it.siren_done;
    item_ch.error_sources <= it.error_sources;
    item_ch.error_asserted <= it.error_asserted;
    do @(posedge clk); while (!item_ch.ready);
    predict_status_step(it);
    if (it.command != CMD_NONE) n_sent++;
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_idling(input bit src, input bit snk);
    src_idle = src;
    snk_idle <= snk;
  endtask

  task automatic cfg_transfer(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic write_thresholds(input logic [PEDAL_W-1:0] apps_lim,
                                  input logic [PEDAL_W-1:0] plaus_lim,
                                  input logic [VOLT_W-1:0] min_volt);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_transfer(REG_IMPL_APPS, DATA_W'(apps_lim));
    cfg_transfer(REG_PLAUS_RST, DATA_W'(plaus_lim));
    cfg_transfer(REG_MIN_VOLT, DATA_W'(min_volt));
    cfg_ch.valid <= 1'b0;
    pred_apps_lim = apps_lim;
    pred_plaus_lim = plaus_lim;
    pred_min_volt = min_volt;
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.command = CMD_W'($urandom_range(3, 0));
    it.accel_sensor_a = PEDAL_W'($urandom);
    it.accel_sensor_b = PEDAL_W'($urandom);
    it.brake_pressed = coin();
    it.rtd_button = coin();
    it.rear_node_running = coin();
    it.inverter_fault = coin();
    it.bus_voltage = VOLT_W'($urandom);
    it.siren_done = coin();
    it.error_sources = ERR_W'($urandom);
    it.error_asserted = coin();
    return it;
  endfunction

  function automatic item_t make_tick(input int a, input int b, input logic brake,
                                      input logic button, input logic rear, input logic fault,
                                      input int volt, input logic done);
    item_t it;
    it = rand_item();
    it.command = CMD_TICK;
    it.accel_sensor_a = PEDAL_W'(a);
    it.accel_sensor_b = PEDAL_W'(b);
    it.brake_pressed = brake;
    it.rtd_button = button;
    it.rear_node_running = rear;
    it.inverter_fault = fault;
    it.bus_voltage = VOLT_W'(volt);
    it.siren_done = done;
    return it;
  endfunction

  function automatic item_t err_item(input logic [ERR_W-1:0] mask, input logic set);
    item_t it;
    it = rand_item();
    it.command = CMD_ERROR;
    it.error_sources = mask;
    it.error_asserted = set;
    return it;
  endfunction

  function automatic item_t cmd_item(input logic [CMD_W-1:0] cmd);
    item_t it;
    it = rand_item();
    it.command = cmd;
    return it;
  endfunction

  // tick with healthy nodes and bus voltage and a pedal that raises no implausibility under the current thresholds
  function automatic item_t healthy_tick(input logic brake, input logic button, input logic done);
    int lim;
    int vhi;
    lim = (pred_plaus_lim > 0) ? int'(pred_plaus_lim) - 1 : 0;
    if (int'(pred_apps_lim) < lim) lim = int'(pred_apps_lim);
    vhi = (pred_min_volt > 10000) ? 16383 : 10000;
    return make_tick($urandom_range(lim, 0), $urandom_range(lim, 0), brake, button, 1'b1, 1'b0,
                     $urandom_range(vhi, pred_min_volt), done);
  endfunction

  function automatic item_t pedal_tick(input int apps, input logic brake);
    item_t it;
    int other;
    it = healthy_tick(brake, coin(), coin());
    other = $urandom_range(apps, 0);
    it.accel_sensor_a = PEDAL_W'(coin() ? apps : other);
    it.accel_sensor_b = PEDAL_W'((it.accel_sensor_a == apps) ? other : apps);
    return it;
  endfunction

  task automatic send_drive_cycle();
    int n;
    if (pred_cond[ERR_W-1:0] != 4'hF && $urandom_range(1, 0)) send_item(err_item(4'hF, 1'b0));
    n = $urandom_range(3, 0);
    repeat (n) send_item(healthy_tick(coin(), 1'b0, coin()));
    send_item(healthy_tick(1'b1, 1'b1, 1'b0));
    n = $urandom_range(4, 0);
    repeat (n) begin
      if ($urandom_range(3, 0) == 0) send_item(make_tick($urandom_range(1023, 0),
        $urandom_range(1023, 0), coin(), coin(), coin(), coin(),
        $urandom_range(16383, 0), 1'b0));
      else send_item(healthy_tick(coin(), coin(), 1'b0));
    end
    send_item(healthy_tick(coin(), coin(), 1'b1));
    n = $urandom_range(6, 0);
    repeat (n) send_item(healthy_tick(coin(), coin(), coin()));
  endtask

  task automatic send_error_episode();
    logic [ERR_W-1:0] mask;
    int n;
    mask = ERR_W'($urandom_range(15, 0));
    send_item(err_item(mask, 1'b1));
    n = $urandom_range(3, 0);
    repeat (n) send_item(healthy_tick(coin(), coin(), coin()));
    if ($urandom_range(3, 0) != 0) send_item(err_item(mask, 1'b0));
  endtask

  task automatic send_pedal_episode();
    int hi_apps;
    int n;
    hi_apps = (pred_apps_lim >= 1023) ? 1023 : $urandom_range(1023, pred_apps_lim + 1);
    send_item(pedal_tick(hi_apps, 1'b1));
    n = $urandom_range(3, 0);
    repeat (n) send_item(pedal_tick($urandom_range(1023, 0), coin()));
    send_item(healthy_tick(1'b0, 1'b0, 1'b0));
  endtask

  task automatic random_traffic(input int target);
    int pick;
    while (n_sent < target) begin
      if ($urandom_range(39, 0) == 0) set_idling(coin(), coin());
      if ($urandom_range(59, 0) == 0) wait_drained();
      pick = $urandom_range(99, 0);
      if (pick < 50) send_drive_cycle();
      else if (pick < 65) send_error_episode();
      else if (pick < 77) send_pedal_episode();
      else if (pick < 87) send_item(cmd_item(CMD_RESET));
      else send_item(rand_item());
    end
  endtask

  task automatic test_directed();
    send_item(cmd_item(CMD_RESET));
    send_item(err_item(4'b0101, 1'b1));
    send_item(err_item(4'hF, 1'b0));
    send_item(make_tick(0, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 1'b0));
    send_item(make_tick(49, 10, 1'b0, 1'b0, 1'b1, 1'b1, 3000, 1'b0));
    send_item(make_tick(49, 10, 1'b0, 1'b0, 1'b1, 1'b0, 2999, 1'b0));
    send_item(make_tick(10, 49, 1'b0, 1'b0, 1'b1, 1'b0, 3000, 1'b0));
    send_item(make_tick(0, 0, 1'b0, 1'b0, 1'b1, 1'b0, 10000, 1'b0));
    send_item(make_tick(0, 0, 1'b1, 1'b0, 1'b1, 1'b0, 10000, 1'b0));
    // pedal exactly at the implausibility level stays plausible
    send_item(make_tick(250, 250, 1'b1, 1'b1, 1'b1, 1'b0, 16383, 1'b0));
    // siren checked even with bad conditions
    send_item(make_tick(0, 0, 1'b0, 1'b0, 1'b0, 1'b1, 0, 1'b0));
    send_item(make_tick(0, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 1'b1));
    send_item(cmd_item(CMD_RESET));
    send_item(make_tick(0, 0, 1'b0, 1'b0, 1'b1, 1'b0, 5000, 1'b0));
    // blinking light carried through siren and running
    send_item(make_tick(0, 0, 1'b1, 1'b1, 1'b1, 1'b0, 5000, 1'b0));
    send_item(cmd_item(CMD_RESET));
    send_item(make_tick(0, 0, 1'b1, 1'b1, 1'b1, 1'b0, 5000, 1'b0));
    send_item(make_tick(0, 0, 1'b0, 1'b0, 1'b1, 1'b0, 5000, 1'b1));
    send_item(make_tick(1023, 0, 1'b1, 1'b0, 1'b1, 1'b0, 5000, 1'b0));
    send_item(cmd_item(CMD_RESET));
    send_item(make_tick(1000, 1000, 1'b0, 1'b0, 1'b1, 1'b0, 5000, 1'b0));
    send_item(make_tick(49, 0, 1'b0, 1'b0, 1'b1, 1'b0, 5000, 1'b0));
    send_item(err_item(4'hF, 1'b1));
    send_item(make_tick(0, 0, 1'b1, 1'b0, 1'b1, 1'b0, 5000, 1'b0));
    send_item(err_item(4'hF, 1'b0));
    send_item(cmd_item(CMD_NONE));
  endtask

  task automatic test_random_default();
    set_idling(1'b1, 1'b1);
    random_traffic(n_sent + 1000);
  endtask

  task automatic test_threshold_settings();
    write_thresholds('0, '0, '0);
    random_traffic(n_sent + 120);
    write_thresholds(10'd1000, 10'd1000, 14'd10000);
    random_traffic(n_sent + 120);
    repeat (3) begin
      write_thresholds(PEDAL_W'($urandom_range(1000, 0)), PEDAL_W'($urandom_range(1000, 0)),
                       VOLT_W'($urandom_range(10000, 0)));
      random_traffic(n_sent + 120);
    end
    write_thresholds(IMPL_APPS_RESET, PLAUS_RST_RESET, MIN_VOLT_RESET);
    random_traffic(n_sent + 100);
  endtask

  // result side held off while items keep coming, so the input side stalls
  task automatic test_backpressure();
    set_idling(1'b0, 1'b0);
    hold_req <= hold_req + 1;
    repeat (20) send_item(healthy_tick(coin(), coin(), coin()));
    set_idling(1'b0, 1'b1);
    hold_req <= hold_req + 1;
    random_traffic(n_sent + 20);
    set_idling(1'b1, 1'b1);
  endtask

  task automatic test_drain_pause();
    random_traffic(n_sent + 40);
    wait_drained();
    random_traffic(n_sent + 40);
  endtask

  initial begin
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.command <= CMD_TICK;
    item_ch.accel_sensor_a <= '0;
    item_ch.accel_sensor_b <= '0;
    item_ch.brake_pressed <= 1'b0;
    item_ch.rtd_button <= 1'b0;
    item_ch.rear_node_running <= 1'b0;
    item_ch.inverter_fault <= 1'b0;
    item_ch.bus_voltage <= '0;
    item_ch.siren_done <= 1'b0;
    item_ch.error_sources <= '0;
    item_ch.error_asserted <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_IMPL_APPS;
    cfg_ch.data <= '0;
    snk_idle <= 1'b1;
    pred_status = ST_INIT;
    pred_cond = COND_RESET;
    pred_led = 1'b1;
    pred_light = LIGHT_OFF;
    pred_apps_lim = IMPL_APPS_RESET;
    pred_plaus_lim = PLAUS_RST_RESET;
    pred_min_volt = MIN_VOLT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_default();
    test_backpressure();
    test_drain_pause();
    test_threshold_settings();

    item_ch.valid <= 1'b0;
    for (int i = 0; i < 2000 && expected_results.size() != 0; i++) @(posedge clk);
    repeat (5) @(posedge clk);
    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report("expected result never arrived");
    end
    if (err_count == 0) $display("tb_ready_to_drive_status_fsm: PASS");
    else $display("tb_ready_to_drive_status_fsm: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t ERROR timeout", $time);
    $display("tb_ready_to_drive_status_fsm: FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/rtds_pkg.sv
design/rtds_in_if.sv
design/rtds_out_if.sv
design/rtds_cfg_if.sv
design/rtds_step.sv
design/ready_to_drive_status_fsm.sv
verif/tb_ready_to_drive_status_fsm.sv
